### sv/slpm_pkg.sv
package slpm_pkg;

  // Capacity of the LED chain in pixels
  localparam int unsigned MAX_PIXELS = 4096;
  localparam int unsigned ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned PTR_W      = $clog2(MAX_PIXELS + 1);

  // Field and register widths
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PW_W       = 7;
  localparam int unsigned PA_W       = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // Derived widths
  localparam int unsigned COLS_W  = PW_W + PA_W;
  localparam int unsigned PPIX_W  = 2 * PW_W;
  localparam int unsigned NPIX_W  = 2 * COLS_W;
  localparam int unsigned PANEL_W = 2 * PA_W;
  localparam int unsigned LIN_W   = 2 * PW_W;
  localparam int unsigned IDX_W   = PANEL_W + PPIX_W + 1;
  localparam int unsigned WORD_W  = 3 * BYTE_W;

  // Divider
  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [BYTE_W-1:0] END_MARK = 8'h01;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SEND  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PANELS_ACROSS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PANELS_DOWN   = 2'd3;

  // Byte lanes of a stored pixel word
  localparam logic [1:0] LANE_BLUE  = 2'd0;
  localparam logic [1:0] LANE_RED   = 2'd1;
  localparam logic [1:0] LANE_GREEN = 2'd2;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] dividend;
    logic [PW_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
    logic [PW_W-1:0]    rem;
  } div_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

  // Keep color bytes from looking like the end marker
  function automatic logic [BYTE_W-1:0] clean_byte(input logic [BYTE_W-1:0] b);
    return (b == END_MARK) ? '0 : b;
  endfunction

endpackage

### sv/slpm_if.sv
interface slpm_in_if import slpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [BYTE_W-1:0]  red;
  logic [BYTE_W-1:0]  green;
  logic [BYTE_W-1:0]  blue;

  modport source (output valid, op, pos_x, pos_y, red, green, blue, input ready);
  modport sink (input valid, op, pos_x, pos_y, red, green, blue, output ready);
  modport monitor (input valid, ready, op, pos_x, pos_y, red, green, blue);
endinterface

interface slpm_out_if import slpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              frame_end;

  modport source (output valid, tx_byte, frame_end, input ready);
  modport sink (input valid, tx_byte, frame_end, output ready);
  modport monitor (input valid, ready, tx_byte, frame_end);
endinterface

### sv/slpm_div.sv
module slpm_div import slpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [COORD_W-1:0]   quo_q, quo_d;
  logic [PW_W-1:0]      rem_q, rem_d;
  logic [PW_W-1:0]      dvs_q, dvs_d;
  logic [PW_W:0]        trial;
  logic [PW_W:0]        diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[COORD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[COORD_W-2:0], fits};
      rem_d = fits ? diff[PW_W-1:0] : trial[PW_W-1:0];
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

### sv/slpm_store.sv
module slpm_store import slpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_wr_t         wr_i,
  input  store_rd_t         rd_i,
  output logic [WORD_W-1:0] rdata_o,
  output logic              clr_busy_o
);

  logic [WORD_W-1:0] mem [MAX_PIXELS];
  logic [WORD_W-1:0] rdata_q;
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  // Sweep zeros through every word after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == ADDR_W'(MAX_PIXELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_comb begin
    we    = clr_busy_q | wr_i.we;
    waddr = clr_busy_q ? clr_addr_q : wr_i.addr;
    wdata = clr_busy_q ? '0 : wr_i.data;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_i.re) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

### sv/serpentine_led_panel_mapper.sv
// Pixel write: ready stays low while the shared radix-2 divider runs for x then y and the mapped
// word is written, one write at a time; an off-matrix write frees it at the bounds check.
// Send: the pointer is checked and the store read, then the result beat lands in the output
// register once it is free; the next item is taken only after that, one send at a time.
// Reset: registers return to an 8x8 single panel, the read pointer to zero, and the store
// is swept to zero with ready held low meanwhile.
module serpentine_led_panel_mapper import slpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  slpm_in_if.sink               in_if,
  slpm_out_if.source            out_if
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_CHECK     = 4'd1;
  localparam logic [3:0] ST_DIVX      = 4'd2;
  localparam logic [3:0] ST_DIVY      = 4'd3;
  localparam logic [3:0] ST_MAP1      = 4'd4;
  localparam logic [3:0] ST_MAP2      = 4'd5;
  localparam logic [3:0] ST_WRITE     = 4'd6;
  localparam logic [3:0] ST_SEND_WAIT = 4'd7;
  localparam logic [3:0] ST_SEND_CHK  = 4'd8;
  localparam logic [3:0] ST_SEND_OUT  = 4'd9;

  // Configuration registers, used as written
  logic [PW_W-1:0] pw_q, ph_q;
  logic [PA_W-1:0] pa_q, pd_q;

  // Matrix geometry, refreshed every cycle from the registers. A zero register gives
  // zero columns or rows, so every write misses the bounds check.
  logic [COLS_W-1:0] cols_q, rows_q;
  logic [PPIX_W-1:0] ppix_q;
  logic [NPIX_W-1:0] npix_q;

  logic [3:0] state_q, state_d;

  // Captured input beat
  logic [COORD_W-1:0] x_q, y_q;
  logic [BYTE_W-1:0]  r_q, g_q, b_q;

  // Mapping datapath
  logic [PA_W-1:0]     pcol_q, pcol_d, prow_q, prow_d;
  logic [PW_W-1:0]     px_q, px_d, py_q, py_d;
  logic [PANEL_W-1:0]  panel_q, panel_d;
  logic [LIN_W-1:0]    lin_q, lin_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [PW_W-1:0]     xin;
  logic [PA_W-1:0]     pcol_m;
  logic [IDX_W-2:0]    blk_off;

  // Read pointer kept as pixel index plus byte lane
  logic [PTR_W-1:0] pix_ptr_q, pix_ptr_d;
  logic [1:0]       lane_q, lane_d;
  logic [1:0]       rd_lane_q, rd_lane_d;
  logic             hit_q, hit_d;
  logic             send_hit;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] tx_q, tx_d;
  logic              end_q, end_d;
  logic [BYTE_W-1:0] lane_byte;

  logic              in_accept;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  store_wr_t         st_wr;
  store_rd_t         st_rd;
  logic [WORD_W-1:0] st_rdata;
  logic              clr_busy;

  slpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  slpm_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (st_wr),
    .rd_i       (st_rd),
    .rdata_o    (st_rdata),
    .clr_busy_o (clr_busy)
  );

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= PW_W'(8);
      ph_q <= PW_W'(8);
      pa_q <= PA_W'(1);
      pd_q <= PA_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PANEL_WIDTH:   pw_q <= cfg_data_i[PW_W-1:0];
        REG_PANEL_HEIGHT:  ph_q <= cfg_data_i[PW_W-1:0];
        REG_PANELS_ACROSS: pa_q <= cfg_data_i[PA_W-1:0];
        REG_PANELS_DOWN:   pd_q <= cfg_data_i[PA_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry: one multiply per register stage
  always_ff @(posedge clk_i) begin
    cols_q <= COLS_W'(pw_q) * COLS_W'(pa_q);
    rows_q <= COLS_W'(ph_q) * COLS_W'(pd_q);
    ppix_q <= PPIX_W'(pw_q) * PPIX_W'(ph_q);
    npix_q <= NPIX_W'(cols_q) * NPIX_W'(rows_q);
  end

  assign in_accept = in_if.valid & in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE) & ~clr_busy;

  // Capture the beat on accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q  <= in_if.pos_x;
      y_q  <= in_if.pos_y;
      r_q  <= in_if.red;
      g_q  <= in_if.green;
      b_q  <= in_if.blue;
    end
  end

  // Serpentine mapping terms: mirror the column on odd global rows and the panel
  // order on odd panel rows
  always_comb begin
    xin     = y_q[0] ? (pw_q - PW_W'(1) - px_q) : px_q;
    pcol_m  = prow_q[0] ? (pa_q - PA_W'(1) - pcol_q) : pcol_q;
    blk_off = {{PPIX_W{1'b0}}, panel_q} * {{PANEL_W{1'b0}}, ppix_q};
  end

  // Byte still inside the frame: pointer below min(matrix pixels, capacity)
  assign send_hit = (NPIX_W'(pix_ptr_q) < npix_q) && (pix_ptr_q < PTR_W'(MAX_PIXELS));

  always_comb begin
    case (rd_lane_q)
      LANE_BLUE:  lane_byte = st_rdata[BYTE_W-1:0];
      LANE_RED:   lane_byte = st_rdata[2*BYTE_W-1:BYTE_W];
      LANE_GREEN: lane_byte = st_rdata[3*BYTE_W-1:2*BYTE_W];
      default:    lane_byte = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pcol_d      = pcol_q;
    prow_d      = prow_q;
    px_d        = px_q;
    py_d        = py_q;
    panel_d     = panel_q;
    lin_d       = lin_q;
    idx_d       = idx_q;
    pix_ptr_d   = pix_ptr_q;
    lane_d      = lane_q;
    rd_lane_d   = rd_lane_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q & ~out_if.ready;
    tx_d        = tx_q;
    end_d       = end_q;

    div_req          = '0;
    st_wr.we         = 1'b0;
    st_wr.addr       = idx_q[ADDR_W-1:0];
    st_wr.data       = {clean_byte(g_q), clean_byte(r_q), clean_byte(b_q)};
    st_rd.re         = 1'b0;
    st_rd.addr       = pix_ptr_q[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (in_if.op == OP_SEND) ? ST_SEND_WAIT : ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Drop writes that fall off the matrix
        if ((COLS_W'(x_q) >= cols_q) || (COLS_W'(y_q) >= rows_q)) begin
          state_d = ST_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = x_q;
          div_req.divisor  = pw_q;
          state_d          = ST_DIVX;
        end
      end

      ST_DIVX: begin
        if (div_rsp.done) begin
          pcol_d           = div_rsp.quot[PA_W-1:0];
          px_d             = div_rsp.rem;
          div_req.start    = 1'b1;
          div_req.dividend = y_q;
          div_req.divisor  = ph_q;
          state_d          = ST_DIVY;
        end
      end

      ST_DIVY: begin
        if (div_rsp.done) begin
          prow_d  = div_rsp.quot[PA_W-1:0];
          py_d    = div_rsp.rem;
          state_d = ST_MAP1;
        end
      end

      ST_MAP1: begin
        panel_d = PANEL_W'(pcol_m) + PANEL_W'(prow_q) * PANEL_W'(pa_q);
        lin_d   = LIN_W'(xin) + LIN_W'(py_q) * LIN_W'(pw_q);
        state_d = ST_MAP2;
      end

      ST_MAP2: begin
        idx_d   = IDX_W'(blk_off) + IDX_W'(lin_q);
        state_d = ST_WRITE;
      end

      ST_WRITE: begin
        // Drop writes beyond the chain capacity
        st_wr.we = (idx_q < IDX_W'(MAX_PIXELS));
        state_d  = ST_IDLE;
      end

      ST_SEND_WAIT: begin
        // Let the geometry registers settle after a late config write
        state_d = ST_SEND_CHK;
      end

      ST_SEND_CHK: begin
        hit_d     = send_hit;
        rd_lane_d = lane_q;
        st_rd.re  = send_hit;
        if (send_hit) begin
          if (lane_q == LANE_GREEN) begin
            lane_d    = LANE_BLUE;
            pix_ptr_d = pix_ptr_q + 1'b1;
          end else begin
            lane_d = lane_q + 1'b1;
          end
        end else begin
          // End of frame: wrap the pointer
          lane_d    = LANE_BLUE;
          pix_ptr_d = '0;
        end
        state_d = ST_SEND_OUT;
      end

      ST_SEND_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          tx_d        = hit_q ? lane_byte : END_MARK;
          end_d       = ~hit_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pix_ptr_q   <= '0;
      lane_q      <= LANE_BLUE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pix_ptr_q   <= pix_ptr_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pcol_q    <= pcol_d;
    prow_q    <= prow_d;
    px_q      <= px_d;
    py_q      <= py_d;
    panel_q   <= panel_d;
    lin_q     <= lin_d;
    idx_q     <= idx_d;
    rd_lane_q <= rd_lane_d;
    hit_q     <= hit_d;
    tx_q      <= tx_d;
    end_q     <= end_d;
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.tx_byte   = tx_q;
  assign out_if.frame_end = end_q;

endmodule

### sv/slpm_checker.sv
module slpm_checker import slpm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] tx_byte_i,
  input logic              frame_end_i
);

  // End-of-frame beats carry the marker byte
  a_end_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && frame_end_i) |-> (tx_byte_i == END_MARK))
    else $error("frame end beat without marker byte");

  // Data beats never carry the marker byte
  a_no_mark_in_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !frame_end_i) |-> (tx_byte_i != END_MARK))
    else $error("data beat carries marker byte");

  // A stalled result beat holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(tx_byte_i) && $stable(frame_end_i)))
    else $error("stalled result beat changed");

  // One item at a time: ready drops right after an accepted beat
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while an item is in flight");

endmodule

bind serpentine_led_panel_mapper slpm_checker u_slpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .tx_byte_i   (out_if.tx_byte),
  .frame_end_i (out_if.frame_end)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import slpm_pkg::*;

  // Bound on the whole run, reset sweep of the store included.
  localparam int unsigned LIMIT_CYCLES  = 400000;
  // A pixel write keeps the divider busy after its beat is taken.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STORE_BYTES   = MAX_PIXELS * 3;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              frame_end;
  } tx_beat_t;

  // Tracks the panel layout, the frame store and the transmit pointer, and holds
  // the transmit beats still owed by the block.
  class led_frame_scoreboard;
    logic [PW_W-1:0]   panel_w;
    logic [PW_W-1:0]   panel_h;
    logic [PA_W-1:0]   across;
    logic [PA_W-1:0]   down;
    logic [BYTE_W-1:0] led_bytes [STORE_BYTES];
    int unsigned       tx_ptr;
    tx_beat_t          owed_beats [$];
    int unsigned       mismatches;
    int unsigned       n_dropped;
    int unsigned       n_frame_ends;

    function new();
      panel_w = 8;
      panel_h = 8;
      across  = 1;
      down    = 1;
      foreach (led_bytes[i]) led_bytes[i] = '0;
      tx_ptr       = 0;
      mismatches   = 0;
      n_dropped    = 0;
      n_frame_ends = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PANEL_WIDTH:   panel_w = val[PW_W-1:0];
        REG_PANEL_HEIGHT:  panel_h = val[PW_W-1:0];
        REG_PANELS_ACROSS: across  = val[PA_W-1:0];
        REG_PANELS_DOWN:   down    = val[PA_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_len();
      int unsigned pixels;
      pixels = int'(panel_w) * int'(across) * int'(panel_h) * int'(down);
      if (pixels > MAX_PIXELS) pixels = MAX_PIXELS;
      return pixels * 3;
    endfunction

    function logic [BYTE_W-1:0] strip_mark(input logic [BYTE_W-1:0] v);
      if (v == END_MARK) return '0;
      return v;
    endfunction

    function void store_pixel(input int unsigned x, input int unsigned y,
                              input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                              input logic [BYTE_W-1:0] b);
      int unsigned w, h, pa, pd, lane_x, panel_col, panel_row, chain;
      w  = panel_w;
      h  = panel_h;
      pa = across;
      pd = down;
      if (w == 0 || h == 0 || pa == 0 || pd == 0 || x >= w * pa || y >= h * pd) begin
        n_dropped++;
        return;
      end
      panel_col = x / w;
      panel_row = y / h;
      // odd raster rows run right to left inside a panel
      lane_x = (y % 2 == 1) ? (w - 1 - x % w) : (x % w);
      // odd panel rows take the panels in reverse order
      if (panel_row % 2 == 1) panel_col = pa - 1 - panel_col;
      chain = lane_x + (y % h) * w + (panel_col + panel_row * pa) * w * h;
      if (chain >= MAX_PIXELS) begin
        n_dropped++;
        return;
      end
      led_bytes[chain * 3 + LANE_BLUE]  = strip_mark(b);
      led_bytes[chain * 3 + LANE_RED]   = strip_mark(r);
      led_bytes[chain * 3 + LANE_GREEN] = strip_mark(g);
    endfunction

    function void note_item(input logic op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [BYTE_W-1:0] r,
                            input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] b);
      tx_beat_t beat;
      if (op == OP_WRITE) begin
        store_pixel(x, y, r, g, b);
        return;
      end
      if (tx_ptr < frame_len()) begin
        beat.tx_byte   = led_bytes[tx_ptr];
        beat.frame_end = 1'b0;
        tx_ptr++;
      end else begin
        beat.tx_byte   = END_MARK;
        beat.frame_end = 1'b1;
        tx_ptr         = 0;
      end
      owed_beats.push_back(beat);
    endfunction

    function void check_beat(input logic [BYTE_W-1:0] tx_byte, input logic frame_end);
      tx_beat_t want;
      if (owed_beats.size() == 0) begin
        $error("unexpected beat: tx_byte %0h frame_end %0b", tx_byte, frame_end);
        mismatches++;
        return;
      end
      want = owed_beats.pop_front();
      if (tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %0h, actual %0h", want.tx_byte, tx_byte);
        mismatches++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
        mismatches++;
      end
      if (want.frame_end) n_frame_ends++;
    endfunction

    function int unsigned owed();
      return owed_beats.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  slpm_in_if  pix_in ();
  slpm_out_if tx_out ();

  serpentine_led_panel_mapper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (pix_in),
    .out_if     (tx_out)
  );

  led_frame_scoreboard sb;

  // Sender burst state and receiver stall pattern
  bit          gaps_on;
  int unsigned burst_left;
  logic [7:0]  ready_pattern = 8'hFF;
  logic [2:0]  stall_step = '0;

  int unsigned cycles = 0;
  int unsigned n_writes;
  int unsigned n_sends;
  int unsigned n_layouts;

  always #2 clk_i = ~clk_i;

  // Walk the stall pattern one bit per cycle to pace the receiver.
  always @(posedge clk_i) begin
    tx_out.ready <= ready_pattern[stall_step];
    stall_step   <= stall_step + 3'd1;
  end

  // Check every accepted transmit beat against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && tx_out.valid === 1'b1 && tx_out.ready === 1'b1) begin
      sb.check_beat(tx_out.tx_byte, tx_out.frame_end);
    end
  end

  // Bail out if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Skew the intensities toward the end-marker value and the rails.
  function automatic logic [BYTE_W-1:0] pick_intensity();
    case ($urandom_range(0, 9))
      0: return END_MARK;
      1: return 8'h00;
      2: return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Present one item, opening a new burst (after a random gap if gaps are on) when the last one
  // ran out, and hold it until the block takes the beat.
  task automatic push_item(input logic op, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [BYTE_W-1:0] r,
                           input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_in.valid <= 1'b1;
    pix_in.op    <= op;
    pix_in.pos_x <= x;
    pix_in.pos_y <= y;
    pix_in.red   <= r;
    pix_in.green <= g;
    pix_in.blue  <= b;
    do @(posedge clk_i); while (pix_in.ready !== 1'b1);
    sb.note_item(op, x, y, r, g, b);
    if (op == OP_SEND) n_sends++;
    else n_writes++;
  endtask

  // Drop valid, wait for every owed beat, then let a pending pixel write finish.
  task automatic settle();
    pix_in.valid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four layout registers on back-to-back edges.
  task automatic write_layout(input int unsigned pw, input int unsigned ph,
                              input int unsigned pa, input int unsigned pd);
    logic [CFG_IDX_W-1:0]  regs [4] = '{REG_PANEL_WIDTH, REG_PANEL_HEIGHT,
                                        REG_PANELS_ACROSS, REG_PANELS_DOWN};
    logic [CFG_DATA_W-1:0] vals [4];
    vals[0] = CFG_DATA_W'(pw);
    vals[1] = CFG_DATA_W'(ph);
    vals[2] = CFG_DATA_W'(pa);
    vals[3] = CFG_DATA_W'(pd);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    n_layouts++;
  endtask

  // Run random traffic on one layout; most writes land inside the matrix when it is not empty.
  task automatic run_layout(input int unsigned pw, input int unsigned ph,
                            input int unsigned pa, input int unsigned pd,
                            input int unsigned items, input int unsigned send_pct);
    int unsigned cols, rows;
    logic op;
    logic [COORD_W-1:0] x, y;
    settle();
    write_layout(pw, ph, pa, pd);
    cols    = pw * pa;
    rows    = ph * pd;
    gaps_on = ($urandom_range(0, 3) != 0);
    ready_pattern <= gaps_on ? (8'($urandom) | 8'h01) : 8'hFF;
    repeat (items) begin
      op = ($urandom_range(0, 99) < send_pct) ? OP_SEND : OP_WRITE;
      if (cols != 0 && rows != 0 && $urandom_range(0, 99) < 85) begin
        x = COORD_W'($urandom_range(0, ((cols > 1024) ? 1024 : cols) - 1));
        y = COORD_W'($urandom_range(0, ((rows > 1024) ? 1024 : rows) - 1));
      end else begin
        x = COORD_W'($urandom_range(0, 1023));
        y = COORD_W'($urandom_range(0, 1023));
      end
      push_item(op, x, y, pick_intensity(), pick_intensity(), pick_intensity());
    end
  endtask

  initial begin
    sb         = new();
    n_writes   = 0;
    n_sends    = 0;
    n_layouts  = 0;
    burst_left = 0;
    gaps_on    = 1'b0;

    // Drive every input to a known value before the first edge.
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_PANEL_WIDTH;
    cfg_data_i   <= '0;
    pix_in.valid <= 1'b0;
    pix_in.op    <= OP_WRITE;
    pix_in.pos_x <= '0;
    pix_in.pos_y <= '0;
    pix_in.red   <= '0;
    pix_in.green <= '0;
    pix_in.blue  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a 2x2 grid of single-pixel panels gives a 12-byte frame, so a whole
    // frame and its end marker fit in 13 sends. Odd panel rows flip the panel order.
    write_layout(1, 1, 2, 2);
    push_item(OP_WRITE, 0, 0, END_MARK, 8'hFF, 8'h00);
    push_item(OP_WRITE, 1, 0, 8'hFF, END_MARK, 8'h80);
    push_item(OP_WRITE, 0, 1, 8'h00, 8'h00, END_MARK);
    push_item(OP_WRITE, 1, 1, 8'h7F, 8'hFE, 8'h02);
    // off the matrix in x, in y, and at the far corner of the coordinate range
    push_item(OP_WRITE, 2, 0, 8'h55, 8'h55, 8'h55);
    push_item(OP_WRITE, 0, 2, 8'hAA, 8'hAA, 8'hAA);
    push_item(OP_WRITE, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
    // read the frame out, take the end marker, then one more to show the wrap
    repeat (14) push_item(OP_SEND, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);

    // Random: small grids first so frames wrap often, then the register extremes,
    // capacity overflow and empty matrices from a zero register.
    run_layout(2, 2, 2, 2, 70, 50);
    run_layout(3, 2, 2, 3, 70, 45);
    run_layout(1, 1, 1, 1, 40, 50);
    run_layout(8, 8, 1, 1, 60, 40);
    run_layout(64, 1, 1, 1, 50, 40);
    run_layout(1, 64, 1, 1, 50, 40);
    run_layout(64, 64, 2, 1, 60, 20);
    run_layout(64, 64, 16, 16, 50, 20);
    run_layout(127, 127, 31, 31, 40, 20);
    run_layout(0, 4, 2, 2, 30, 40);
    run_layout(4, 0, 2, 2, 30, 40);
    run_layout(2, 2, 0, 2, 30, 40);
    run_layout(2, 2, 2, 0, 30, 40);
    run_layout(4, 4, 4, 4, 60, 40);
    // shrink the frame below the read pointer left by the last layout
    run_layout(1, 1, 1, 2, 40, 50);
    run_layout(5, 3, 3, 2, 70, 40);
    repeat (4) begin
      run_layout($urandom_range(1, 10), $urandom_range(1, 10),
                 $urandom_range(1, 4), $urandom_range(1, 4), 50, 45);
    end

    settle();
    $display("Covered %0d pixel writes (%0d dropped) and %0d sends over %0d panel layouts",
             n_writes, sb.n_dropped, n_sends, n_layouts);
    $display("End-of-frame markers checked: %0d", sb.n_frame_ends);
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### serpentine_led_panel_mapper.f
sv/slpm_pkg.sv
sv/slpm_if.sv
sv/slpm_div.sv
sv/slpm_store.sv
sv/serpentine_led_panel_mapper.sv
sv/slpm_checker.sv
tb/sv/tb.sv
